// ===== design/ole_pkg.sv =====
package ole_pkg;

  // command codes of the input channel
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_MISSING  = 3'd4,
    ST_LISTED   = 3'd5
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    init_ins;
    logic    init_del;
    logic    init_list;
    logic    step_ins;
    logic    step_del;
    logic    list_rd;
    logic    out_load;
    logic    out_list;
    status_t out_status;
  } ole_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic ins_done;
    logic del_end;
    logic del_found;
    logic list_more;
    logic out_last;
  } ole_sts_t;

endpackage

// ===== design/ole_channels.sv =====
// request channel: command and operand
interface ole_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] operand;

  modport source (output valid, cmd, operand, input ready);
  modport sink   (input valid, cmd, operand, output ready);
endinterface

// result channel: status, element and last marker
interface ole_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] element;
  logic               last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

// ===== design/ole_datapath.sv =====
module ole_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ole_pkg::ole_ctl_t  ctl,
  output ole_pkg::ole_sts_t  sts,
  input  logic signed [31:0] in_operand,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_element,
  output logic               out_last
);
  import ole_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // entry store, one write and one registered read per cycle
  logic signed [31:0] mem [CAPACITY];

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      ptr_r;
  logic               pend_r;
  logic               found_r;
  logic [IW-1:0]      addr_r;
  logic signed [31:0] val_r;
  logic signed [31:0] rd_r;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  logic               ins_hit;
  logic               ins_done;
  logic               del_end;
  logic               list_more;
  logic               list_last;

  // scan status
  assign ins_hit   = pend_r && (rd_r < val_r);
  assign ins_done  = ins_hit || (!pend_r && (ptr_r == '0));
  assign del_end   = !pend_r && (ptr_r == count_r);
  assign list_more = ptr_r < count_r;
  assign list_last = (CW'(addr_r) + CW'(1)) == count_r;

  assign sts.empty     = count_r == '0;
  assign sts.full      = count_r == CW'(CAPACITY);
  assign sts.ins_done  = ins_done;
  assign sts.del_end   = del_end;
  assign sts.del_found = found_r;
  assign sts.list_more = list_more;
  assign sts.out_last  = out_last;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IW'(ptr_r);
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_r;
    if (ctl.step_ins) begin
      // walk down from the top, moving entries not below the operand up one slot
      if (ins_hit) begin
        wr_en   = 1'b1;
        wr_addr = addr_r + IW'(1);
        wr_data = val_r;
      end else if (pend_r) begin
        wr_en   = 1'b1;
        wr_addr = addr_r + IW'(1);
      end else if (ptr_r == '0) begin
        wr_en   = 1'b1;
        wr_data = val_r;
      end
      if (!ins_hit && (ptr_r != '0)) begin
        rd_en   = 1'b1;
        rd_addr = IW'(ptr_r - CW'(1));
      end
    end
    if (ctl.step_del) begin
      // walk up; after the match every entry moves down one slot
      if (pend_r && found_r) begin
        wr_en   = 1'b1;
        wr_addr = addr_r - IW'(1);
      end
      rd_en = list_more;
    end
    if (ctl.list_rd) begin
      rd_en = 1'b1;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // scan control and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctl.init_ins) begin
        ptr_r  <= count_r;
        pend_r <= 1'b0;
      end
      if (ctl.init_del || ctl.init_list) begin
        ptr_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (ctl.step_ins) begin
        if (rd_en) begin
          ptr_r  <= ptr_r - CW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (ins_done) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (ctl.step_del) begin
        if (pend_r && !found_r && (rd_r == val_r)) begin
          found_r <= 1'b1;
        end
        if (list_more) begin
          ptr_r  <= ptr_r + CW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (del_end && found_r) begin
          count_r <= count_r - CW'(1);
        end
      end
      if (ctl.list_rd) begin
        ptr_r <= ptr_r + CW'(1);
      end
    end
  end

  // operand, read address and result payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      val_r <= in_operand;
    end
    if (rd_en) begin
      addr_r <= rd_addr;
    end
    if (ctl.out_load) begin
      if (ctl.out_list) begin
        out_status  <= ST_LISTED;
        out_element <= rd_r;
        out_last    <= list_last;
      end else begin
        out_status  <= ctl.out_status;
        out_element <= '0;
        out_last    <= 1'b1;
      end
    end
  end

endmodule

// ===== design/ole_controller.sv =====
module ole_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ole_pkg::ole_ctl_t ctl,
  input  ole_pkg::ole_sts_t sts
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_LS_RD,
    S_LS_LOAD,
    S_LS_OUT,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.capture = 1'b1;
          case (in_cmd)
            CMD_INSERT: begin
              if (sts.full) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_FULL;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_RESP;
              end else begin
                ctl.init_ins = 1'b1;
                state_nxt    = S_INS;
              end
            end
            CMD_DELETE: begin
              if (sts.empty) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_RESP;
              end else begin
                ctl.init_del = 1'b1;
                state_nxt    = S_DEL;
              end
            end
            CMD_LIST: begin
              if (sts.empty) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_RESP;
              end else begin
                ctl.init_list = 1'b1;
                state_nxt     = S_LS_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        ctl.step_ins = 1'b1;
        if (sts.ins_done) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_INSERTED;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_DEL: begin
        ctl.step_del = 1'b1;
        if (sts.del_end) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = sts.del_found ? ST_DELETED : ST_MISSING;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_LS_RD: begin
        ctl.list_rd = 1'b1;
        state_nxt   = S_LS_LOAD;
      end
      S_LS_LOAD: begin
        // show the first entry and prefetch the next
        ctl.out_load  = 1'b1;
        ctl.out_list  = 1'b1;
        ctl.list_rd   = sts.list_more;
        out_valid_nxt = 1'b1;
        state_nxt     = S_LS_OUT;
      end
      S_LS_OUT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            ctl.out_load = 1'b1;
            ctl.out_list = 1'b1;
            ctl.list_rd  = sts.list_more;
          end
        end
      end
      S_RESP: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/ordered_list_engine.sv =====
// channel   | dir | payload                    | handshake
// in_chan   | in  | cmd[1:0], operand[31:0]    | valid / ready
// out_chan  | out | status[2:0], element[31:0] | valid / ready
//           |     | last                       |
//
// one request at a time; n is the number of stored entries
// insert walks down over up to n entries, delete walks over all n and list
// reads out all n; the walk over the entry store with its single
// read port and single write port paces these steps
// reset clears the entry count and scan state; store contents are not cleared
// a stalled result holds the block, in_chan.ready stays low until it drains
module ordered_list_engine #(
  parameter int CAPACITY = 32
) (
  input logic       clk,
  input logic       rst_n,
  ole_in_if.sink    in_chan,
  ole_out_if.source out_chan
);
  import ole_pkg::*;

  ole_ctl_t ctl;
  ole_sts_t sts;

  // sequencer
  ole_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // entry store and result registers
  ole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_operand  (in_chan.operand),
    .out_status  (out_chan.status),
    .out_element (out_chan.element),
    .out_last    (out_chan.last)
  );

endmodule
